[src/iwtf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwtf_pkg: shared types and constants
// Widths, register indexes, CORDIC table and controller/datapath command types.
// ----------------------------------------------------------------------------
package iwtf_pkg;

    localparam int CordicStepsDef = 16;
    localparam int CordicStepsMax = 24;

    localparam logic [2:0] REG_AX_OFF = 3'd0;
    localparam logic [2:0] REG_AY_OFF = 3'd1;
    localparam logic [2:0] REG_AZ_OFF = 3'd2;
    localparam logic [2:0] REG_GX_OFF = 3'd3;
    localparam logic [2:0] REG_GY_OFF = 3'd4;
    localparam logic [2:0] REG_GZ_OFF = 3'd5;
    localparam logic [2:0] REG_WINDOW = 3'd6;

    localparam logic [9:0] WindowReset = 10'd156;

    // atan(2^-i) in Q.16 degrees
    function automatic logic signed [23:0] atan_lut(input logic [4:0] idx);
        logic signed [23:0] r;
        begin
            case (idx)
                5'd0:  r = 24'sd2949120;
                5'd1:  r = 24'sd1740967;
                5'd2:  r = 24'sd919879;
                5'd3:  r = 24'sd466945;
                5'd4:  r = 24'sd234379;
                5'd5:  r = 24'sd117304;
                5'd6:  r = 24'sd58666;
                5'd7:  r = 24'sd29335;
                5'd8:  r = 24'sd14668;
                5'd9:  r = 24'sd7334;
                5'd10: r = 24'sd3667;
                5'd11: r = 24'sd1833;
                5'd12: r = 24'sd917;
                5'd13: r = 24'sd458;
                5'd14: r = 24'sd229;
                5'd15: r = 24'sd115;
                5'd16: r = 24'sd57;
                5'd17: r = 24'sd29;
                5'd18: r = 24'sd14;
                5'd19: r = 24'sd7;
                5'd20: r = 24'sd4;
                5'd21: r = 24'sd2;
                5'd22: r = 24'sd1;
                default: r = 24'sd0;
            endcase
            return r;
        end
    endfunction

    // controller -> datapath
    typedef struct packed {
        logic load;        // capture input item, add offsets, update sums
        logic gyro_mul;    // form gyro products
        logic gyro_div;    // one divide-by-1000 step
        logic cor_init;    // start CORDIC for current angle
        logic cor_step;    // one CORDIC iteration
        logic cor_done;    // store current angle
        logic cor_sel;     // 0: pitch, 1: roll
        logic fuse_mul;    // fusion products for angle cor_sel
        logic fuse_add;    // fusion sum, derivative update
        logic cnt_inc;     // bump sample count, decide emit
        logic mean_init;   // start mean computation for field mean_idx
        logic mean_mul;    // sum*100
        logic mean_step;   // one divide step
        logic mean_done;   // store mean field
        logic [2:0] mean_idx;
        logic clear;       // clear window sums
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic emit;        // window full
        logic div_last;    // divider on last step
        logic cor_last;    // CORDIC on last step
    } t_sts;

endpackage

[src/imu_window_tilt_features_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_window_tilt_features_unit: windowed IMU means and fused tilt slopes
// One sample in, optionally one result of eight int16 features out.
// ----------------------------------------------------------------------------
// One item at a time. A sample keeps the unit busy after it is accepted
// (gyro products, reciprocal divide by 1000, two CORDIC runs through one
// shared shift-add unit, fusion, count update), so a new item is accepted
// only once the previous one is through. A sample that closes a window adds
// eight 38-step divides through one serial divider, plus the result
// hand-over and any wait for the output register to free up.
// s_axis_tready is high only while the sequencer is idle. The result sits
// in an output register until taken; the next item is accepted meanwhile.
// Configuration: index 0..5 are the axis offsets, 6 the window size; write
// only while idle.
module imu_window_tilt_features_unit #(
    parameter int CORDIC_STEPS = iwtf_pkg::CordicStepsDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_we,
    input  logic [2:0]   i_cfg_idx,
    input  logic [11:0]  i_cfg_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // accel_x[13:0], accel_y[27:14], accel_z[41:28], gyro_x[54:42],
    // gyro_y[67:55], gyro_z[80:68], elapsed_ms[96:81], zero pad
    input  logic [103:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // mean_accel_x/y/z, mean_gyro_x/y/z, pitch_slope, roll_slope, 16b each
    output logic [127:0] m_axis_tdata
);
    import iwtf_pkg::*;

    t_cmd        w_cmd;
    t_sts        w_sts;
    logic        w_busy, w_result;
    logic [127:0] w_means;
    logic        r_valid;
    logic        w_in_fire;

    assign s_axis_tready = ~w_busy;
    assign w_in_fire     = s_axis_tvalid & s_axis_tready;

    iwtf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_fire  (w_in_fire),
        .i_out_free (~r_valid | m_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd),
        .o_busy     (w_busy),
        .o_result   (w_result)
    );

    iwtf_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_ax       ($signed(s_axis_tdata[13:0])),
        .i_ay       ($signed(s_axis_tdata[27:14])),
        .i_az       ($signed(s_axis_tdata[41:28])),
        .i_gx       ($signed(s_axis_tdata[54:42])),
        .i_gy       ($signed(s_axis_tdata[67:55])),
        .i_gz       ($signed(s_axis_tdata[80:68])),
        .i_ms       (s_axis_tdata[96:81]),
        .o_means    (w_means)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_result) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_result) m_axis_tdata <= w_means;
    end
    assign m_axis_tvalid = r_valid;
endmodule

[src/iwtf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwtf_ctrl: sequencer
// Steps one sample through gyro integration, two CORDIC runs, fusion and,
// at window end, eight serial divides.
// ----------------------------------------------------------------------------
module iwtf_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_fire,
    input  logic          i_out_free,
    input  iwtf_pkg::t_sts i_sts,
    output iwtf_pkg::t_cmd o_cmd,
    output logic          o_busy,
    output logic          o_result
);
    import iwtf_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_GMUL  = 4'd1;
    localparam logic [3:0] S_GDIV  = 4'd2;
    localparam logic [3:0] S_CINIT = 4'd3;
    localparam logic [3:0] S_CSTEP = 4'd4;
    localparam logic [3:0] S_CDONE = 4'd5;
    localparam logic [3:0] S_FMUL  = 4'd6;
    localparam logic [3:0] S_FADD  = 4'd7;
    localparam logic [3:0] S_CNT   = 4'd8;
    localparam logic [3:0] S_DEC   = 4'd9;
    localparam logic [3:0] S_MINIT = 4'd10;
    localparam logic [3:0] S_MMUL  = 4'd11;
    localparam logic [3:0] S_MSTEP = 4'd12;
    localparam logic [3:0] S_MDONE = 4'd13;
    localparam logic [3:0] S_WAIT  = 4'd14;

    logic [3:0] r_state, n_state;
    logic       r_sel, n_sel;
    logic [2:0] r_idx, n_idx;
    logic       w_res;

    always_comb begin
        n_state = r_state;
        n_sel   = r_sel;
        n_idx   = r_idx;
        w_res   = 1'b0;
        o_cmd   = '0;
        o_cmd.cor_sel  = r_sel;
        o_cmd.mean_idx = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_in_fire) begin
                    o_cmd.load = 1'b1;
                    n_state = S_GMUL;
                end
            end
            S_GMUL: begin
                o_cmd.gyro_mul = 1'b1;
                n_state = S_GDIV;
            end
            S_GDIV: begin
                o_cmd.gyro_div = 1'b1;
                if (i_sts.div_last) begin
                    n_sel = 1'b0;
                    n_state = S_CINIT;
                end
            end
            S_CINIT: begin
                o_cmd.cor_init = 1'b1;
                n_state = S_CSTEP;
            end
            S_CSTEP: begin
                o_cmd.cor_step = 1'b1;
                if (i_sts.cor_last) begin
                    n_state = S_CDONE;
                end
            end
            S_CDONE: begin
                o_cmd.cor_done = 1'b1;
                n_state = S_FMUL;
            end
            S_FMUL: begin
                o_cmd.fuse_mul = 1'b1;
                n_state = S_FADD;
            end
            S_FADD: begin
                o_cmd.fuse_add = 1'b1;
                if (r_sel) begin
                    n_state = S_CNT;
                end else begin
                    n_sel = 1'b1;
                    n_state = S_CINIT;
                end
            end
            S_CNT: begin
                o_cmd.cnt_inc = 1'b1;
                n_state = S_DEC;
            end
            S_DEC: begin
                if (i_sts.emit) begin
                    n_idx = 3'd0;
                    n_state = S_MINIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MINIT: begin
                o_cmd.mean_init = 1'b1;
                n_state = S_MMUL;
            end
            S_MMUL: begin
                o_cmd.mean_mul = 1'b1;
                n_state = S_MSTEP;
            end
            S_MSTEP: begin
                o_cmd.mean_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MDONE;
                end
            end
            S_MDONE: begin
                o_cmd.mean_done = 1'b1;
                if (r_idx == 3'd7) begin
                    n_state = S_WAIT;
                end else begin
                    n_idx = r_idx + 3'd1;
                    n_state = S_MINIT;
                end
            end
            S_WAIT: begin
                if (i_out_free) begin
                    o_cmd.clear = 1'b1;
                    w_res = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= 1'b0;
            r_idx   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_sel   <= n_sel;
            r_idx   <= n_idx;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_result = w_res;
endmodule

[src/iwtf_dp.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwtf_dp: datapath
// Offset add, window sums, gyro integration, shared CORDIC, fusion,
// and a serial restoring divider for the window means.
// ----------------------------------------------------------------------------
module iwtf_dp #(
    parameter int CORDIC_STEPS = iwtf_pkg::CordicStepsDef
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  iwtf_pkg::t_cmd       i_cmd,
    output iwtf_pkg::t_sts       o_sts,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_idx,
    input  logic [11:0]          i_cfg_data,
    input  logic signed [13:0]   i_ax,
    input  logic signed [13:0]   i_ay,
    input  logic signed [13:0]   i_az,
    input  logic signed [12:0]   i_gx,
    input  logic signed [12:0]   i_gy,
    input  logic signed [12:0]   i_gz,
    input  logic [15:0]          i_ms,
    output logic [127:0]         o_means
);
    import iwtf_pkg::*;

    localparam int Steps = (CORDIC_STEPS < CordicStepsMax) ? CORDIC_STEPS : CordicStepsMax;
    localparam logic [4:0] LastStep = 5'(Steps - 1);
    localparam int Qb = 38; // dividend bits: |31b sum * 100| < 2^38
    // ceil(2^38 / 1000): exact floor(n / 1000) for any n below 2^32
    localparam logic [28:0] Recip1000 = 29'd274877907;

    // configuration
    logic signed [11:0] r_off [6];
    logic [9:0]         r_win;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_off[k] <= '0;
            r_win <= WindowReset;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_WINDOW) begin
                r_win <= i_cfg_data[9:0];
            end else if (i_cfg_idx <= REG_GZ_OFF) begin
                r_off[i_cfg_idx] <= $signed(i_cfg_data);
            end
        end
    end

    // effective window
    logic [9:0] w_weff;
    assign w_weff = (r_win == 10'd0) ? 10'd1 : r_win;

    // corrected sample values
    logic signed [14:0] r_v [6];
    logic signed [23:0] r_sum [6];
    logic signed [14:0] w_v [6];
    logic [15:0]        r_ms;
    assign w_v[0] = 15'(i_ax) + 15'(r_off[0]);
    assign w_v[1] = 15'(i_ay) + 15'(r_off[1]);
    assign w_v[2] = 15'(i_az) + 15'(r_off[2]);
    assign w_v[3] = 15'(i_gx) + 15'(r_off[3]);
    assign w_v[4] = 15'(i_gy) + 15'(r_off[4]);
    assign w_v[5] = 15'(i_gz) + 15'(r_off[5]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_sum[k] <= '0;
        end else if (i_cmd.load) begin
            for (int k = 0; k < 6; k++) r_sum[k] <= r_sum[k] + 24'(w_v[k]);
        end else if (i_cmd.clear) begin
            for (int k = 0; k < 6; k++) r_sum[k] <= '0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int k = 0; k < 6; k++) r_v[k] <= w_v[k];
            r_ms <= i_ms;
        end
    end

    // ---------------- gyro integration ----------------
    // three phases: magnitude + 500, reciprocal multiply, signed accumulate
    logic signed [31:0] r_gprod [2];
    logic [28:0]        r_gmag [2];
    logic               r_gneg [2];
    logic [57:0]        r_grec [2];
    logic signed [31:0] r_gterm [2];
    logic [1:0]         r_gph;
    logic signed [31:0] w_gp0, w_gp1;
    logic [28:0]        w_gmag [2];
    logic signed [31:0] w_ginc [2];

    assign w_gp0 = 32'(r_v[4]) * $signed({1'b0, r_ms});
    assign w_gp1 = 32'(r_v[3]) * $signed({1'b0, r_ms});

    always_comb begin
        for (int k = 0; k < 2; k++) begin
            w_gmag[k] = r_gprod[k][31] ? 29'(-r_gprod[k]) : r_gprod[k][28:0];
            w_ginc[k] = r_gneg[k] ? -$signed({12'b0, r_grec[k][57:38]})
                                  : $signed({12'b0, r_grec[k][57:38]});
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gyro_mul) begin
            r_gprod[0] <= w_gp0;
            r_gprod[1] <= w_gp1;
        end
        if (i_cmd.gyro_div && r_gph == 2'd0) begin
            for (int k = 0; k < 2; k++) begin
                r_gneg[k] <= r_gprod[k][31];
                r_gmag[k] <= w_gmag[k] + 29'd500;
            end
        end
        if (i_cmd.gyro_div && r_gph == 2'd1) begin
            for (int k = 0; k < 2; k++) r_grec[k] <= 58'(r_gmag[k]) * 58'(Recip1000);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gph      <= '0;
            r_gterm[0] <= '0;
            r_gterm[1] <= '0;
        end else if (i_cmd.gyro_mul) begin
            r_gph <= '0;
        end else if (i_cmd.gyro_div) begin
            r_gph <= r_gph + 2'd1;
            if (r_gph == 2'd2) begin
                for (int k = 0; k < 2; k++) r_gterm[k] <= r_gterm[k] + w_ginc[k];
            end
        end
    end

    // ---------------- mean divider ----------------
    // magnitude dividend left-aligned in 47b, divisor up to 26b
    logic [46:0] r_dvd;
    logic [25:0] r_dvs;
    logic [26:0] r_rem;
    logic [46:0] r_quo;
    logic [5:0]  r_dcnt;
    logic        r_dneg;
    logic [26:0] w_rsh;
    logic [27:0] w_rdf;
    logic [46:0] w_quo_next;
    logic signed [31:0] r_msrc;
    logic signed [38:0] r_mprod;
    logic [37:0] w_mmag;

    assign w_rsh = {r_rem[25:0], r_dvd[46]};
    assign w_rdf = {1'b0, w_rsh} - {2'b0, r_dvs};
    assign w_quo_next = {r_quo[45:0], ~w_rdf[27]};
    assign w_mmag = r_mprod[38] ? 38'(-r_mprod) : r_mprod[37:0];

    assign o_sts.div_last = i_cmd.gyro_div ? (r_gph == 2'd2) : (r_dcnt == 6'd1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dcnt <= '0;
        end else if (i_cmd.mean_mul) begin
            r_mprod <= 39'(r_msrc) * 39'sd100;
            r_dcnt  <= 6'd0;
        end else if (i_cmd.mean_step) begin
            if (r_dcnt == 6'd0) begin
                r_dvd  <= {w_mmag, 9'b0};
                r_dneg <= r_mprod[38];
                r_dvs  <= {8'b0, 18'({8'b0, w_weff}) << 8};
                r_rem  <= '0;
                r_quo  <= '0;
                r_dcnt <= 6'(Qb + 1);
            end else begin
                r_dcnt <= r_dcnt - 6'd1;
                if (r_dcnt != 6'd1) begin
                    r_rem <= w_rdf[27] ? w_rsh : w_rdf[26:0];
                    r_quo <= w_quo_next;
                    r_dvd <= {r_dvd[45:0], 1'b0};
                end
            end
        end
    end

    // ---------------- CORDIC ----------------
    logic signed [39:0] r_cx, r_cy;
    logic signed [24:0] r_cz;
    logic [4:0]         r_ci;
    logic signed [14:0] w_yin;
    logic signed [39:0] w_dx, w_dy;
    assign w_yin = i_cmd.cor_sel ? r_v[1] : r_v[0];
    assign w_dx = r_cy >>> r_ci;
    assign w_dy = r_cx >>> r_ci;
    assign o_sts.cor_last = (r_ci == LastStep);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cor_init) begin
            r_ci <= '0;
            if (r_v[2] < 0) begin
                r_cx <= -(40'(r_v[2]) <<< 16);
                r_cy <= -(40'(w_yin) <<< 16);
                r_cz <= (w_yin >= 0) ? 25'sd11796480 : -25'sd11796480;
            end else begin
                r_cx <= 40'(r_v[2]) <<< 16;
                r_cy <= 40'(w_yin) <<< 16;
                r_cz <= '0;
            end
        end else if (i_cmd.cor_step) begin
            r_ci <= r_ci + 5'd1;
            if (r_cy >= 0) begin
                r_cx <= r_cx + w_dx;
                r_cy <= r_cy - w_dy;
                r_cz <= r_cz + 25'(atan_lut(r_ci));
            end else begin
                r_cx <= r_cx - w_dx;
                r_cy <= r_cy + w_dy;
                r_cz <= r_cz - 25'(atan_lut(r_ci));
            end
        end
    end

    logic signed [24:0] w_ang;
    logic signed [25:0] w_ang_b;
    logic signed [23:0] r_acc;
    logic               w_zero;
    assign w_zero  = (r_v[2] == 0) && (w_yin == 0);
    assign w_ang   = w_zero ? 25'sd0 : r_cz;
    assign w_ang_b = i_cmd.cor_sel ? (26'(w_ang) + 26'sd128)
                                   : (-26'(w_ang) - 26'sd340787 + 26'sd128);
    always_ff @(posedge i_clk) begin
        if (i_cmd.cor_done) r_acc <= 24'(w_ang_b >>> 8);
    end

    // ---------------- fusion ----------------
    logic signed [48:0] r_fa, r_fb;
    logic signed [23:0] r_prev [2];
    logic signed [31:0] r_dsum [2];
    logic signed [49:0] w_fs;
    logic signed [33:0] w_fq;
    logic signed [23:0] w_fused;
    assign w_fs = 50'(r_fa) + 50'(r_fb) + 50'sd32768;
    assign w_fq = 34'(w_fs >>> 16);
    assign w_fused = (w_fq > 34'sd8388607) ? 24'sd8388607 :
                     (w_fq < -34'sd8388608) ? -24'sd8388608 : 24'(w_fq);

    always_ff @(posedge i_clk) begin
        if (i_cmd.fuse_mul) begin
            r_fa <= 49'(r_gterm[i_cmd.cor_sel]) * 49'sd19661;
            r_fb <= 49'(r_acc) * 49'sd45875;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 2; k++) begin
                r_prev[k] <= '0;
                r_dsum[k] <= '0;
            end
        end else if (i_cmd.fuse_add) begin
            r_dsum[i_cmd.cor_sel] <= r_dsum[i_cmd.cor_sel] + 32'(w_fused)
                                     - 32'(r_prev[i_cmd.cor_sel]);
            r_prev[i_cmd.cor_sel] <= w_fused;
        end else if (i_cmd.clear) begin
            r_dsum[0] <= '0;
            r_dsum[1] <= '0;
        end
    end

    // ---------------- sample count ----------------
    logic [9:0] r_cnt;
    logic       r_emit;
    logic [9:0] w_cnt1;
    assign w_cnt1 = r_cnt + 10'd1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_emit <= 1'b0;
        end else if (i_cmd.cnt_inc) begin
            r_cnt  <= w_cnt1;
            r_emit <= (w_cnt1 >= w_weff) || (w_cnt1 == 10'd0);
        end else if (i_cmd.clear) begin
            r_cnt  <= '0;
            r_emit <= 1'b0;
        end
    end
    assign o_sts.emit = r_emit;

    // ---------------- means ----------------
    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_init) begin
            case (i_cmd.mean_idx)
                3'd6:    r_msrc <= r_dsum[0];
                3'd7:    r_msrc <= r_dsum[1];
                default: r_msrc <= 32'(r_sum[i_cmd.mean_idx]);
            endcase
        end
    end

    logic signed [47:0] w_q;
    logic signed [15:0] w_qs;
    assign w_q  = r_dneg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
    assign w_qs = (w_q > 48'sd32767) ? 16'sd32767 :
                  (w_q < -48'sd32768) ? -16'sd32768 : 16'(w_q);

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_done) o_means[16*i_cmd.mean_idx +: 16] <= w_qs;
    end
endmodule

[src/iwtf_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwtf_checker: port-level checks
// Handshake and sequencing properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module iwtf_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("accepted two items back to back");

    a_no_out_without_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> !s_axis_tready || $past(!s_axis_tready))
        else $error("result without work");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("valid after reset");
endmodule

bind imu_window_tilt_features_unit iwtf_checker u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

[dv/imu_window_tilt_features_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_window_tilt_features_unit_tb: self-checking bench for the tilt unit
// Streams IMU samples with random gaps and back-pressure, models windowed
// means and fused tilt slopes in a scoreboard, checks every result item.
// ----------------------------------------------------------------------------
module imu_window_tilt_features_unit_tb;
    import iwtf_pkg::*;

    localparam int  NumRandom   = 1100;
    localparam int  SettleCyc   = 600;      // exceeds worst per-item latency
    localparam longint CycLimit = 4000000;

    typedef struct packed {
        logic        [15:0] ms;
        logic signed [12:0] gz;
        logic signed [12:0] gy;
        logic signed [12:0] gx;
        logic signed [13:0] az;
        logic signed [13:0] ay;
        logic signed [13:0] ax;
    } t_sample;

    // ------------------------------------------------------------------------
    // Scoreboard: own copy of unit state, predicts result items.
    // ------------------------------------------------------------------------
    class tilt_feature_scoreboard;
        longint   offs[6];
        int       win_size;
        longint   axis_acc[6];
        longint   gyro_term[2];
        longint   slope_acc[2];
        longint   prev_fused[2];
        int       count;
        logic [127:0] pending_features[$];
        int       n_err;

        function new();
            foreach (offs[i]) begin
                offs[i] = 0;
                axis_acc[i] = 0;
            end
            foreach (gyro_term[i]) begin
                gyro_term[i] = 0;
                slope_acc[i] = 0;
                prev_fused[i] = 0;
            end
            win_size = int'(WindowReset);
            count = 0;
            n_err = 0;
        endfunction

        static function longint wrap(longint v, int bits);
            return (v <<< (64 - bits)) >>> (64 - bits);
        endfunction

        static function longint atan2_q16(longint y0, longint x0);
            longint x, y, z, dx, dy;
            x = x0 * 65536;
            y = y0 * 65536;
            z = 0;
            if (x0 == 0 && y0 == 0) return 0;
            if (x < 0) begin
                z = (y >= 0) ? 180 * 65536 : -180 * 65536;
                x = -x;
                y = -y;
            end
            for (int i = 0; i < CordicStepsDef && i < CordicStepsMax; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += longint'(atan_lut(i[4:0]));
                end else begin
                    x -= dx; y += dy; z -= longint'(atan_lut(i[4:0]));
                end
            end
            return z;
        endfunction

        static function logic [15:0] mean16(longint sum, longint w);
            longint q;
            q = (sum * 100) / (256 * w);
            if (q < -32768) q = -32768;
            if (q > 32767) q = 32767;
            return q[15:0];
        endfunction

        function void set_reg(logic [2:0] idx, logic [11:0] val);
            if (idx < REG_WINDOW) offs[idx] = longint'($signed(val));
            else if (idx == REG_WINDOW) win_size = int'(val[9:0]);
        endfunction

        function void note_sample(t_sample s);
            longint v[6], acc[2], fused, p, inc, w;
            logic [127:0] r;
            v[0] = longint'(s.ax) + offs[0];
            v[1] = longint'(s.ay) + offs[1];
            v[2] = longint'(s.az) + offs[2];
            v[3] = longint'(s.gx) + offs[3];
            v[4] = longint'(s.gy) + offs[4];
            v[5] = longint'(s.gz) + offs[5];
            foreach (v[i]) axis_acc[i] = wrap(axis_acc[i] + v[i], 24);
            // pitch integrates gyro y, roll integrates gyro x
            for (int i = 0; i < 2; i++) begin
                p = v[i == 0 ? 4 : 3] * longint'(s.ms);
                inc = (p >= 0) ? (p + 500) / 1000 : -((-p + 500) / 1000);
                gyro_term[i] = wrap(gyro_term[i] + inc, 32);
            end
            acc[0] = (-atan2_q16(v[0], v[2]) - 340787 + 128) >>> 8;
            acc[1] = (atan2_q16(v[1], v[2]) + 128) >>> 8;
            for (int i = 0; i < 2; i++) begin
                fused = (gyro_term[i] * 19661 + acc[i] * 45875 + 32768) >>> 16;
                if (fused < -8388608) fused = -8388608;
                if (fused > 8388607) fused = 8388607;
                slope_acc[i] = wrap(slope_acc[i] + fused - prev_fused[i], 32);
                prev_fused[i] = fused;
            end
            count = (count + 1) & 1023;
            w = (win_size == 0) ? 1 : win_size;
            if (count < w && count != 0) return;
            for (int i = 0; i < 6; i++) begin
                r[16*i +: 16] = mean16(axis_acc[i], w);
                axis_acc[i] = 0;
            end
            r[96 +: 16]  = mean16(slope_acc[0], w);
            r[112 +: 16] = mean16(slope_acc[1], w);
            slope_acc[0] = 0;
            slope_acc[1] = 0;
            count = 0;
            pending_features.push_back(r);
        endfunction

        function void check_result(logic [127:0] got);
            string names[8] = '{"mean_accel_x", "mean_accel_y", "mean_accel_z",
                                "mean_gyro_x", "mean_gyro_y", "mean_gyro_z",
                                "pitch_slope", "roll_slope"};
            logic [127:0] exp_r;
            if (pending_features.size() == 0) begin
                $error("result item with nothing expected: %h", got);
                n_err++;
                return;
            end
            exp_r = pending_features.pop_front();
            for (int i = 0; i < 8; i++)
                if (exp_r[16*i +: 16] !== got[16*i +: 16]) begin
                    $error("%s expected %0d actual %0d", names[i],
                           $signed(exp_r[16*i +: 16]), $signed(got[16*i +: 16]));
                    n_err++;
                end
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [11:0]  i_cfg_data = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;    // ax, ay, az, gx, gy, gz, ms, pad
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [127:0] m_axis_tdata;         // 3 accel means, 3 gyro means, 2 slopes

    tilt_feature_scoreboard sb = new();
    longint cyc = 0;

    imu_window_tilt_features_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc > CycLimit) begin
            $display("imu_window_tilt_features_unit test failed");
            $finish;
        end
    end

    // result side: random stalls, tready only dropped when a gap is drawn
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = $urandom_range(0, 4);
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            sb.check_result(m_axis_tdata);
        end
    end

    // sender: random gap, then hold the item until accepted
    task automatic send_sample(t_sample s);
        int gap;
        gap = $urandom_range(0, 4);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, s};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_sample(s);
    endtask

    // drain: every result back, then let a resultless item finish
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_features.size() != 0) @(posedge i_clk);
        repeat (SettleCyc) @(posedge i_clk);
    endtask

    // one write per cycle; caller lowers the enable afterward
    task automatic cfg_write(logic [2:0] idx, logic [11:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        sb.set_reg(idx, val);
    endtask

    function automatic t_sample rand_sample();
        t_sample s;
        if ($urandom_range(0, 4) == 0) begin
            // near zero: hits zero vectors and sign flips in atan2
            s.ax = 14'(int'($urandom_range(0, 6)) - 3);
            s.ay = 14'(int'($urandom_range(0, 6)) - 3);
            s.az = 14'(int'($urandom_range(0, 6)) - 3);
            s.gx = 13'(int'($urandom_range(0, 6)) - 3);
            s.gy = 13'(int'($urandom_range(0, 6)) - 3);
            s.gz = 13'(int'($urandom_range(0, 6)) - 3);
        end else begin
            s.ax = 14'(int'($urandom_range(0, 10239)) - 5120);
            s.ay = 14'(int'($urandom_range(0, 10239)) - 5120);
            s.az = 14'(int'($urandom_range(0, 10239)) - 5120);
            s.gx = 13'(int'($urandom_range(0, 5119)) - 2560);
            s.gy = 13'(int'($urandom_range(0, 5119)) - 2560);
            s.gz = 13'(int'($urandom_range(0, 5119)) - 2560);
        end
        s.ms = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 65535))
                                           : 16'($urandom_range(0, 20));
        return s;
    endfunction

    function automatic t_sample mk(int ax, int ay, int az, int gx, int gy, int gz,
                                   int ms);
        t_sample s;
        s.ax = 14'(ax); s.ay = 14'(ay); s.az = 14'(az);
        s.gx = 13'(gx); s.gy = 13'(gy); s.gz = 13'(gz);
        s.ms = 16'(ms);
        return s;
    endfunction

    initial begin
        t_sample dir_q[$];
        int sent, ph, n, wsel;
        logic [11:0] off;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes, zero vector, negative z both y signs
        dir_q.push_back(mk(0, 0, 0, 0, 0, 0, 0));
        dir_q.push_back(mk(5119, 5119, 5119, 2559, 2559, 2559, 65535));
        dir_q.push_back(mk(-5120, -5120, -5120, -2560, -2560, -2560, 65535));
        dir_q.push_back(mk(5119, -5120, 5119, -2560, 2559, 0, 1));
        dir_q.push_back(mk(100, 50, -300, 10, -10, 5, 2));
        dir_q.push_back(mk(-100, -50, -300, -10, 10, -5, 2));
        dir_q.push_back(mk(0, 0, -1, 0, 0, 0, 1000));
        dir_q.push_back(mk(0, 1, 0, 0, 0, 0, 500));
        dir_q.push_back(mk(1, -1, 0, 1, -1, 0, 499));
        dir_q.push_back(mk(-5120, 0, 0, 2559, -2560, 0, 65535));
        dir_q.push_back(mk(0, 0, 5119, 0, 0, 0, 3));
        dir_q.push_back(mk(2560, 2560, 256, -1, 1, -1, 2));
        foreach (dir_q[i]) send_sample(dir_q[i]);

        // window lowered below the current count: emits on the next sample
        drain();
        cfg_write(REG_WINDOW, 12'd4);
        i_cfg_we <= 1'b0;
        send_sample(mk(5119, -5120, -5120, 2559, -2560, 2559, 65535));
        send_sample(mk(-5120, 5119, 5119, -2560, 2559, -2560, 65535));

        sent = 0;
        ph = 0;
        while (sent < NumRandom) begin
            drain();    // sender holds off until all results are back
            for (int r = 0; r < 6; r++) begin
                case (ph)
                    0: off = 12'h800;
                    1: off = 12'h7FF;
                    2: off = 12'h000;
                    default: off = 12'($urandom_range(0, 4095));
                endcase
                cfg_write(r[2:0], off);
            end
            wsel = ph % 7;
            case (wsel)
                0: cfg_write(REG_WINDOW, 12'd1);
                1: cfg_write(REG_WINDOW, 12'd0);
                2: cfg_write(REG_WINDOW, 12'd1023);
                3: cfg_write(REG_WINDOW, 12'd156);
                default: cfg_write(REG_WINDOW, 12'($urandom_range(2, 12)));
            endcase
            i_cfg_we <= 1'b0;
            n = (wsel == 2 || wsel == 3) ? 40 : 70;
            repeat (n) begin
                send_sample(rand_sample());
                sent++;
            end
            ph++;
        end

        drain();
        if (sb.n_err == 0 && sb.pending_features.size() == 0) begin
            $display("imu_window_tilt_features_unit test passed");
        end else begin
            $display("imu_window_tilt_features_unit test failed");
        end
        $finish;
    end

endmodule
